[design/y2nv_pkg.sv]
package y2nv_pkg;

  localparam int PAIRS_W   = 12;
  localparam int ROWS_W    = 13;
  localparam int ROW_CNT_W = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [PAIRS_W-1:0] PAIRS_RESET = 12'd320;
  localparam logic [ROWS_W-1:0]  ROWS_RESET  = 13'd480;
  localparam logic [ROWS_W-1:0]  ROW_LIMIT   = 13'd4096;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAIRS_PER_ROW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS    = 2'd1;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } yuyv_in_t;

  typedef struct packed {
    logic [7:0] y_out_first;
    logic [7:0] y_out_second;
    logic       chroma_valid;
    logic [7:0] cb_avg;
    logic [7:0] cr_avg;
    logic       row_end;
    logic       frame_end;
  } nv12_out_t;

  // line store entry: Cr in the high byte, Cb in the low byte
  typedef struct packed {
    logic [7:0] cr;
    logic [7:0] cb;
  } chroma_pair_t;

endpackage

[design/y2nv_ram.sv]
module y2nv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/yuyv_to_nv12_converter_core.sv]
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready  | y2nv_pkg::yuyv_in_t, one macropixel
// out_    | output    | out_valid/out_ready  | y2nv_pkg::nv12_out_t, one result
// cfg_    | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// One request in, one result out, one request per cycle sustained while out_ready
// holds. The rate is set by the single port pair of the chroma line store:
// even rows write it, odd rows read it, never both in one cycle.
// Reset (rst_n, synchronous) clears counters, valids and loads the default
// geometry; the line store is not cleared. A stall on out_ propagates back to
// in_ready through the stage 1 register and the output register.
module yuyv_to_nv12_converter_core #(
  parameter int MAX_PAIRS = 2048
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  y2nv_pkg::yuyv_in_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output y2nv_pkg::nv12_out_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [y2nv_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [y2nv_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import y2nv_pkg::*;

  // column counter addresses the line store directly
  localparam int CW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  // compare width: holds pairs_per_row, MAX_PAIRS and column + 1
  localparam int EW = ((CW > PAIRS_W) ? CW : PAIRS_W) + 1;
  localparam int MAX_PAIRS_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS + 1) : 1;

  // stage 1 control, travels alongside the line store read
  typedef struct packed {
    logic odd;
    logic last_col;
    logic last_row;
  } s1_ctrl_t;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [PAIRS_W-1:0] pairs_r;
  logic [ROWS_W-1:0]  rows_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pairs_r <= PAIRS_RESET;
      rows_r  <= ROWS_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PAIRS_PER_ROW) begin
        pairs_r <= cfg_data[PAIRS_W-1:0];
      end else if (cfg_index == REG_FRAME_ROWS) begin
        rows_r <= cfg_data[ROWS_W-1:0];
      end
    end
  end

  // effective geometry: zero acts as one, clamp to the store and row limit
  logic [EW-1:0]     eff_pairs;
  logic [ROWS_W-1:0] eff_rows;

  always_comb begin
    eff_pairs = EW'(pairs_r);
    if (pairs_r == '0) begin
      eff_pairs = EW'(1);
    end else if (eff_pairs > EW'(MAX_PAIRS_W'(MAX_PAIRS))) begin
      eff_pairs = EW'(MAX_PAIRS_W'(MAX_PAIRS));
    end
    eff_rows = rows_r;
    if (rows_r == '0) begin
      eff_rows = ROWS_W'(1);
    end else if (rows_r > ROW_LIMIT) begin
      eff_rows = ROW_LIMIT;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: position tracking and line store access
  // ---------------------------------------------------------------------------
  logic [CW-1:0]        col_r, col_nxt;
  logic [ROW_CNT_W-1:0] row_r, row_nxt;
  logic                 in_fire;
  logic                 last_col, last_row, odd_row;
  logic                 s1_valid_r;
  logic                 s1_adv;
  s1_ctrl_t             s1_ctrl_r;
  yuyv_in_t             s1_data_r;
  logic                 ram_we, ram_re;
  chroma_pair_t         ram_wdata, ram_rdata;

  assign in_fire  = in_valid && in_ready;
  // a column or row beyond the last one (after a geometry change) ends it
  assign last_col = (EW'(col_r) + EW'(1)) >= eff_pairs;
  assign last_row = (ROWS_W'(row_r) + ROWS_W'(1)) >= eff_rows;
  assign odd_row  = row_r[0];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_CNT_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Even rows write, odd rows read: never both in one cycle. An odd-row read
  // that follows the matching even-row write sees it, since the write lands
  // at the edge before the read is issued.
  assign ram_we    = in_fire && !odd_row;
  assign ram_re    = in_fire && odd_row;
  assign ram_wdata = '{cr: in_data.chroma_red, cb: in_data.chroma_blue};

  y2nv_ram #(
    .WIDTH ($bits(chroma_pair_t)),
    .DEPTH (MAX_PAIRS)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: line store data ready, average and register the result
  // ---------------------------------------------------------------------------
  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
      s1_ctrl_r <= '{odd: odd_row, last_col: last_col, last_row: last_row};
    end
  end

  logic [8:0] cb_sum, cr_sum;
  nv12_out_t  res;
  logic       out_valid_r;
  nv12_out_t  out_data_r;

  assign cb_sum = {1'b0, ram_rdata.cb} + {1'b0, s1_data_r.chroma_blue};
  assign cr_sum = {1'b0, ram_rdata.cr} + {1'b0, s1_data_r.chroma_red};

  always_comb begin
    res.y_out_first  = s1_data_r.luma_first;
    res.y_out_second = s1_data_r.luma_second;
    res.chroma_valid = s1_ctrl_r.odd;
    res.cb_avg       = s1_ctrl_r.odd ? cb_sum[8:1] : 8'd0;
    res.cr_avg       = s1_ctrl_r.odd ? cr_sum[8:1] : 8'd0;
    res.row_end      = s1_ctrl_r.last_col;
    res.frame_end    = s1_ctrl_r.last_col && s1_ctrl_r.last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_store_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("line store read and written in one cycle");

  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last_col) |=> (col_r == '0))
    else $error("column counter did not wrap at row end");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid && !out_ready))
    else $error("input stalled without a full pipeline");

  a_frame_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.frame_end || out_data.row_end))
    else $error("frame end without row end");

  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.chroma_valid) |->
      (out_data.cb_avg == 8'd0 && out_data.cr_avg == 8'd0))
    else $error("chroma averages set on an even row");

endmodule
